// ----- rtl/core/gapc_pkg.sv -----
// Shared constants, types and register codes for the global average pool block.
package gapc_pkg;

  // Payload widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned CHIDX_W    = 10;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CCOUNT_W   = 11;
  localparam int unsigned PCOUNT_W   = 17;
  localparam int unsigned PX_W       = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_CHANNELS = 1024;
  localparam int unsigned DEF_MAX_PIXELS   = 65536;

  // Depth of the queue between front and back
  localparam int unsigned OPQ_DEPTH = 4;

  // Reset values of the registers
  localparam logic [CCOUNT_W-1:0] CCOUNT_RST = CCOUNT_W'(1);
  localparam logic [PCOUNT_W-1:0] PCOUNT_RST = PCOUNT_W'(1);
  localparam logic [RECIP_W-1:0]  RECIP_RST  = RECIP_W'(65536);

  // Rounding and saturation
  localparam int unsigned ROUND_HALF = 32768;
  localparam logic signed [AVG_W-1:0] AVG_POS_MAX = 16'sh7fff;
  localparam logic signed [AVG_W-1:0] AVG_NEG_MAX = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_PIXEL_COUNT   = 2'd1,
    CFG_RECIPROCAL    = 2'd2
  } cfg_reg_e;

  // Classification of one item, made by the front
  typedef struct packed {
    logic first_px;
    logic last_px;
    logic last_ch;
  } gapc_flags_t;

endpackage

// ----- rtl/core/gapc_intf.sv -----
// Handshake interfaces for the input, result and configuration channels.
interface gapc_in_if;
  import gapc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gapc_out_if;
  import gapc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [AVG_W-1:0]   average;
  logic        [CHIDX_W-1:0] channel_index;
  logic                      image_last;
  modport source (output valid, output average, output channel_index, output image_last,
                  input ready);
  modport sink   (input valid, input average, input channel_index, input image_last,
                  output ready);
endinterface

interface gapc_cfg_if;
  import gapc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/gapc_front.sv -----
// Front: accepts items, tracks channel and pixel position, classifies each item.
module gapc_front #(
  parameter int unsigned MAX_CHANNELS = gapc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_PIXELS   = gapc_pkg::DEF_MAX_PIXELS,
  parameter int unsigned CH_W         = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  gapc_in_if.sink                             in_i,
  input  logic [gapc_pkg::CCOUNT_W-1:0]       channel_count_i,
  input  logic [gapc_pkg::PCOUNT_W-1:0]       pixel_count_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output logic signed [gapc_pkg::SAMPLE_W-1:0] op_sample_o,
  output logic [CH_W-1:0]                     op_ch_o,
  output gapc_pkg::gapc_flags_t               op_flags_o
);
  import gapc_pkg::*;

  // Compare widths: hold the count limits and counter + 1
  localparam int unsigned CHC_W = ($clog2(MAX_CHANNELS + 1) > CCOUNT_W) ?
                                  $clog2(MAX_CHANNELS + 1) : CCOUNT_W;
  localparam int unsigned PXC_W = ($clog2(MAX_PIXELS + 1) > PCOUNT_W) ?
                                  $clog2(MAX_PIXELS + 1) : PCOUNT_W;
  // Pixel counter width: grows with the pixel limit
  localparam int unsigned PXQ_W = ($clog2(MAX_PIXELS) > PX_W) ? $clog2(MAX_PIXELS) : PX_W;

  logic [CH_W-1:0]  ch_q, ch_d;
  logic [PXQ_W-1:0] px_q, px_d;
  logic [CHC_W-1:0] nch, cc_ext, ch_next;
  logic [PXC_W-1:0] npx, pc_ext, px_next;
  logic             last_ch, last_px, in_fire;

  // Effective counts: zero means one, clamp at the maximum
  always_comb begin
    cc_ext = CHC_W'(channel_count_i);
    pc_ext = PXC_W'(pixel_count_i);
    if (cc_ext == '0) begin
      nch = CHC_W'(1);
    end else if (cc_ext > CHC_W'(MAX_CHANNELS)) begin
      nch = CHC_W'(MAX_CHANNELS);
    end else begin
      nch = cc_ext;
    end
    if (pc_ext == '0) begin
      npx = PXC_W'(1);
    end else if (pc_ext > PXC_W'(MAX_PIXELS)) begin
      npx = PXC_W'(MAX_PIXELS);
    end else begin
      npx = pc_ext;
    end
  end

  // Classification of the current position
  assign ch_next = CHC_W'(ch_q) + CHC_W'(1);
  assign px_next = PXC_W'(px_q) + PXC_W'(1);
  assign last_ch = (ch_next >= nch);
  assign last_px = (px_next >= npx);

  assign in_fire      = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign op_sample_o  = in_i.sample;
  assign op_ch_o      = ch_q;
  assign op_flags_o   = '{first_px: (px_q == '0), last_px: last_px, last_ch: last_ch};

  // Counter advance
  always_comb begin
    ch_d = ch_q;
    px_d = px_q;
    if (in_fire) begin
      if (last_ch) begin
        ch_d = '0;
        px_d = last_px ? '0 : (px_q + PXQ_W'(1));
      end else begin
        ch_d = ch_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
      px_q <= '0;
    end else begin
      ch_q <= ch_d;
      px_q <= px_d;
    end
  end

endmodule

// ----- rtl/core/gapc_opq.sv -----
// Small queue of classified items between front and back.
module gapc_opq #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = gapc_pkg::OPQ_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_ready_i && rd_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : (wr_ptr_q + AW'(1));
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : (rd_ptr_q + AW'(1));
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/gapc_back.sv -----
// Back: per-channel sum memory, read-modify-write, scaling and result register.
module gapc_back #(
  parameter int unsigned MAX_CHANNELS = gapc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned CH_W         = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 op_valid_i,
  output logic                                 op_ready_o,
  input  logic signed [gapc_pkg::SAMPLE_W-1:0] op_sample_i,
  input  logic [CH_W-1:0]                      op_ch_i,
  input  gapc_pkg::gapc_flags_t                op_flags_i,
  input  logic [gapc_pkg::RECIP_W-1:0]         reciprocal_i,
  gapc_out_if.source                           out_o
);
  import gapc_pkg::*;

  localparam int unsigned PROD_W = SUM_W + RECIP_W + 1;
  localparam int unsigned Q_W    = PROD_W - FRAC_W;

  // Sum memory, entries undefined until a first pixel writes them
  logic [SUM_W-1:0] sum_mem [MAX_CHANNELS];
  logic [SUM_W-1:0] rd_data_q;

  // Stage 1: accumulate
  logic                       s1_valid_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [CH_W-1:0]            s1_ch_q;
  gapc_flags_t                s1_flags_q;
  logic                       s1_fire, pop;
  logic [SUM_W-1:0]           base, new_sum;

  // Last write, forwarded past the memory read
  logic                       fwd_valid_q;
  logic [CH_W-1:0]            fwd_ch_q;
  logic [SUM_W-1:0]           fwd_sum_q;

  // Stage 2: multiply
  logic                       s2_valid_q, s2_ready;
  logic signed [SUM_W-1:0]    s2_sum_q;
  logic [CH_W-1:0]            s2_ch_q;
  logic                       s2_last_q;

  // Stage 3: round and saturate
  logic                       s3_valid_q, s3_ready;
  logic signed [PROD_W-1:0]   s3_prod_q;
  logic [CH_W-1:0]            s3_ch_q;
  logic                       s3_last_q;

  // Output register
  logic                       out_valid_q, out_free;
  logic signed [AVG_W-1:0]    out_avg_q;
  logic [CHIDX_W-1:0]         out_ch_q;
  logic                       out_last_q;

  logic signed [PROD_W-1:0]   prod, rnd;
  logic signed [Q_W-1:0]      quot;
  logic signed [AVG_W-1:0]    avg_sat;
  logic [CH_W+CHIDX_W-1:0]    ch_wide;

  // Handshakes along the pipeline
  assign out_free   = !out_valid_q || out_o.ready;
  assign s3_ready   = !s3_valid_q || out_free;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_fire    = s1_valid_q && (!s1_flags_q.last_px || s2_ready);
  assign op_ready_o = !s1_valid_q || s1_fire;
  assign pop        = op_valid_i && op_ready_o;

  // New running sum
  always_comb begin
    if (s1_flags_q.first_px) begin
      base = '0;
    end else if (fwd_valid_q && (fwd_ch_q == s1_ch_q)) begin
      base = fwd_sum_q;
    end else begin
      base = rd_data_q;
    end
    new_sum = base + SUM_W'(s1_sample_q);
  end

  // Memory port: write from stage 1, registered read on pop
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      sum_mem[s1_ch_q] <= new_sum;
    end
    if (pop) begin
      rd_data_q <= sum_mem[op_ch_i];
    end
  end

  // Scaling math
  assign prod    = $signed(s2_sum_q) * $signed({1'b0, reciprocal_i});
  assign rnd     = s3_prod_q + $signed(PROD_W'(ROUND_HALF));
  assign quot    = $signed(rnd[PROD_W-1:FRAC_W]);
  assign ch_wide = {{CHIDX_W{1'b0}}, s3_ch_q};

  always_comb begin
    if (quot > Q_W'(AVG_POS_MAX)) begin
      avg_sat = AVG_POS_MAX;
    end else if (quot < Q_W'(AVG_NEG_MAX)) begin
      avg_sat = AVG_NEG_MAX;
    end else begin
      avg_sat = quot[AVG_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_sample_q <= op_sample_i;
      s1_ch_q     <= op_ch_i;
      s1_flags_q  <= op_flags_i;
    end
    if (s1_fire) begin
      fwd_ch_q  <= s1_ch_q;
      fwd_sum_q <= new_sum;
    end
    if (s1_fire && s1_flags_q.last_px) begin
      s2_sum_q  <= $signed(new_sum);
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_flags_q.last_ch;
    end
    if (s2_valid_q && s3_ready) begin
      s3_prod_q <= prod;
      s3_ch_q   <= s2_ch_q;
      s3_last_q <= s2_last_q;
    end
    if (s3_valid_q && out_free) begin
      out_avg_q  <= avg_sat;
      out_ch_q   <= ch_wide[CHIDX_W-1:0];
      out_last_q <= s3_last_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_ready_o) begin
        s1_valid_q <= op_valid_i;
      end
      if (s1_fire) begin
        fwd_valid_q <= 1'b1;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_fire && s1_flags_q.last_px;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.average       = out_avg_q;
  assign out_o.channel_index = out_ch_q;
  assign out_o.image_last    = out_last_q;

  // A last-pixel item leaving stage 1 lands in stage 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_flags_q.last_px |=> s2_valid_q && (s2_sum_q == $signed($past(new_sum))))
    else $error("gapc_back: last-pixel sum not carried into multiply stage");

  // A stalled product stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !s3_ready |=> s3_valid_q && $stable(s3_prod_q))
    else $error("gapc_back: product lost while stalled");

  // Forwarded value matches what was written to the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> fwd_valid_q && (fwd_ch_q == $past(s1_ch_q)) && (fwd_sum_q == $past(new_sum)))
    else $error("gapc_back: forward register out of step with memory write");

endmodule

// ----- rtl/core/global_average_pool_channels.sv -----
// Top level of the global average pool: configuration registers, front, queue and back.
//
//  channel  dir  payload                              accepted when
//  cfg_i    in   index[1:0], data[16:0]               valid && ready (ready always high)
//  in_i     in   sample[15:0] signed Q8.8             valid && ready
//  out_o    out  average[15:0], channel_index[9:0],   valid && ready
//                image_last
//
//  One item per cycle unless the output stalls; each item does one read-modify-write
//  of its channel's sum in the back, with a forward register covering back-to-back
//  hits on the same channel. Reset clears counters and valid bits and loads register
//  defaults; the sum memory and payload registers are not cleared. Input and output
//  stall independently through the 4-entry item queue.
module global_average_pool_channels #(
  parameter int unsigned MAX_CHANNELS = gapc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_PIXELS   = gapc_pkg::DEF_MAX_PIXELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gapc_cfg_if.sink    cfg_i,
  gapc_in_if.sink     in_i,
  gapc_out_if.source  out_o
);
  import gapc_pkg::*;

  localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned OP_W  = SAMPLE_W + CH_W + $bits(gapc_flags_t);

  logic [CCOUNT_W-1:0] channel_count_q;
  logic [PCOUNT_W-1:0] pixel_count_q;
  logic [RECIP_W-1:0]  reciprocal_q;

  logic                       push_valid, push_ready, op_valid, op_ready;
  logic signed [SAMPLE_W-1:0] f_sample, b_sample;
  logic [CH_W-1:0]            f_ch, b_ch;
  gapc_flags_t                f_flags, b_flags;
  logic [OP_W-1:0]            wr_op, rd_op;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CCOUNT_RST;
      pixel_count_q   <= PCOUNT_RST;
      reciprocal_q    <= RECIP_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_CHANNEL_COUNT: channel_count_q <= cfg_i.data[CCOUNT_W-1:0];
        CFG_PIXEL_COUNT:   pixel_count_q   <= cfg_i.data[PCOUNT_W-1:0];
        CFG_RECIPROCAL:    reciprocal_q    <= cfg_i.data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  gapc_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_PIXELS   (MAX_PIXELS),
    .CH_W         (CH_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .channel_count_i (channel_count_q),
    .pixel_count_i   (pixel_count_q),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .op_sample_o     (f_sample),
    .op_ch_o         (f_ch),
    .op_flags_o      (f_flags)
  );

  assign wr_op = {f_sample, f_ch, f_flags};
  assign {b_sample, b_ch, b_flags} = rd_op;

  gapc_opq #(
    .WIDTH (OP_W),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (wr_op),
    .rd_valid_o (op_valid),
    .rd_ready_i (op_ready),
    .rd_data_o  (rd_op)
  );

  gapc_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CH_W         (CH_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (op_valid),
    .op_ready_o   (op_ready),
    .op_sample_i  (b_sample),
    .op_ch_i      (b_ch),
    .op_flags_i   (b_flags),
    .reciprocal_i (reciprocal_q),
    .out_o        (out_o)
  );

endmodule

// ----- sim/global_average_pool_channels_tb.sv -----
// Self-checking testbench for the global average pool block: NHWC samples in, channel means out.
`timescale 1ns / 1ps

module global_average_pool_channels_tb;
  import gapc_pkg::*;

  localparam int unsigned POOL_CHANNELS = DEF_MAX_CHANNELS;
  localparam int unsigned POOL_PIXELS   = DEF_MAX_PIXELS;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned RESULTS_WANT  = 48;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic [CHIDX_W-1:0]      channel_index;
    logic                    image_last;
  } pooled_mean_t;

  typedef enum logic [1:0] {
    PACE_ALWAYS,
    PACE_COIN,
    PACE_SPARSE,
    PACE_BLOCKS
  } sink_pace_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  gapc_cfg_if cfg_ch ();
  gapc_in_if  in_ch ();
  gapc_out_if out_ch ();

  global_average_pool_channels dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: registers, per-channel sums and the NHWC counters
  logic [CCOUNT_W-1:0] ccount_reg = CCOUNT_RST;
  logic [PCOUNT_W-1:0] pcount_reg = PCOUNT_RST;
  logic [RECIP_W-1:0]  recip_reg  = RECIP_RST;
  logic [SUM_W-1:0]    channel_sums [POOL_CHANNELS];
  bit                  sum_written  [POOL_CHANNELS];
  int unsigned         chan_ctr = 0;
  int unsigned         pix_ctr  = 0;

  logic signed [SAMPLE_W-1:0] sample_backlog [$];
  pooled_mean_t               pending_means [$];

  int unsigned mismatches   = 0;
  int unsigned means_seen   = 0;
  int unsigned cycle_count  = 0;
  bit          no_gaps      = 1'b0;

  function automatic int unsigned eff_channels(logic [CCOUNT_W-1:0] r);
    if (r == 0) return 1;
    if (r > POOL_CHANNELS) return POOL_CHANNELS;
    return 32'(r);
  endfunction

  function automatic int unsigned eff_pixels(logic [PCOUNT_W-1:0] r);
    if (r == 0) return 1;
    if (r > POOL_PIXELS) return POOL_PIXELS;
    return 32'(r);
  endfunction

  // Sum times Q1.16 reciprocal, round half up, floor shift, saturate to 16 bits
  function automatic logic signed [AVG_W-1:0] scaled_mean(logic [SUM_W-1:0] sum);
    longint prod;
    longint q;
    prod = longint'($signed(sum)) * longint'(recip_reg) + 64'sd32768;
    q = prod >>> FRAC_W;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[AVG_W-1:0];
  endfunction

  // One accepted sample: update the channel sum, queue a mean on the last pixel
  task automatic accumulate_sample(logic signed [SAMPLE_W-1:0] s);
    int unsigned  nch;
    int unsigned  npx;
    int unsigned  ch;
    bit           last_ch;
    bit           last_px;
    pooled_mean_t m;
    nch = eff_channels(ccount_reg);
    npx = eff_pixels(pcount_reg);
    ch = chan_ctr;
    last_ch = (ch + 1 >= nch);
    last_px = (pix_ctr + 1 >= npx);
    if (ch >= POOL_CHANNELS) ch = 0;
    if (pix_ctr == 0) channel_sums[ch] = {{16{s[SAMPLE_W-1]}}, s};
    else channel_sums[ch] = channel_sums[ch] + {{16{s[SAMPLE_W-1]}}, s};
    sum_written[ch] = 1'b1;
    if (last_px) begin
      m.average = scaled_mean(channel_sums[ch]);
      m.channel_index = ch[CHIDX_W-1:0];
      m.image_last = last_ch;
      pending_means.push_back(m);
    end
    if (last_ch) begin
      chan_ctr = 0;
      pix_ctr = last_px ? 0 : pix_ctr + 1;
    end else begin
      chan_ctr = ch + 1;
    end
  endtask

  // Items left until the current image closes, under the present registers
  function automatic int unsigned items_to_image_end();
    int unsigned nch;
    int unsigned npx;
    int unsigned this_px;
    nch = eff_channels(ccount_reg);
    npx = eff_pixels(pcount_reg);
    this_px = (chan_ctr + 1 >= nch) ? 1 : nch - chan_ctr;
    if (pix_ctr + 1 >= npx) return this_px;
    return this_px + (npx - pix_ctr - 1) * nch;
  endfunction

  // A new channel count must not make the block add into a sum never written
  function automatic bit channel_count_safe(int unsigned n_eff);
    if (pix_ctr == 0) return 1'b1;
    if (!sum_written[chan_ctr % POOL_CHANNELS]) return 1'b0;
    for (int unsigned c = 0; c < n_eff; c++) begin
      if (!sum_written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic program_register(cfg_reg_e which, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (which)
      CFG_CHANNEL_COUNT: ccount_reg = value[CCOUNT_W-1:0];
      CFG_PIXEL_COUNT:   pcount_reg = value[PCOUNT_W-1:0];
      CFG_RECIPROCAL:    recip_reg  = value[RECIP_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every item is taken and every mean has come, then let the pipe drain
  task automatic settle_pipeline();
    while (sample_backlog.size() != 0 || in_ch.valid || pending_means.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("global_average_pool_channels_tb NOT OK");
      $finish;
    end
  end

  // Sample driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni && (!in_ch.valid || in_ch.ready)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        in_ch.valid  <= 1'b1;
        in_ch.sample <= sample_backlog.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: ready follows a random pace that is picked anew whenever its timer runs out
  sink_pace_e  pace       = PACE_ALWAYS;
  int unsigned pace_timer = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (pace_timer == 0) begin
        pace <= sink_pace_e'($urandom_range(0, 3));
        pace_timer <= $urandom_range(20, 120);
      end else begin
        pace_timer <= pace_timer - 1;
      end
      case (pace)
        PACE_ALWAYS: out_ch.ready <= 1'b1;
        PACE_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        PACE_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= (pace_timer[3:0] < 4);
      endcase
    end
  end

  // Monitor: check a taken mean first, then predict from a taken sample
  always @(posedge clk_i) begin
    pooled_mean_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        means_seen++;
        if (pending_means.size() == 0) begin
          report_mismatch("unexpected mean, channel", int'(out_ch.channel_index), -1);
        end else begin
          want = pending_means.pop_front();
          if (out_ch.average !== want.average)
            report_mismatch("average", int'(out_ch.average), int'(want.average));
          if (out_ch.channel_index !== want.channel_index)
            report_mismatch("channel_index", int'(out_ch.channel_index),
                            int'(want.channel_index));
          if (out_ch.image_last !== want.image_last)
            report_mismatch("image_last", int'(out_ch.image_last), int'(want.image_last));
        end
      end
      if (in_ch.valid && in_ch.ready) accumulate_sample(in_ch.sample);
    end
  end

  // Stimulus: directed cases, then random phases with register changes between them
  initial begin : stimulus
    int unsigned          random_items;
    int unsigned          n_items;
    int unsigned          cand;
    int unsigned          npx;
    logic [CFG_DATA_W-1:0] word;
    random_items = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CHANNEL_COUNT;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: one channel, one pixel, unit reciprocal; extremes pass through
    @(negedge clk_i);
    sample_backlog = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001};
    settle_pipeline();

    // Two channels, two pixels, half: means reach both rails
    program_register(CFG_CHANNEL_COUNT, 17'd2);
    program_register(CFG_PIXEL_COUNT, 17'd2);
    program_register(CFG_RECIPROCAL, 17'd32768);
    @(negedge clk_i);
    sample_backlog = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    settle_pipeline();

    // Reciprocal above one saturates both ways
    program_register(CFG_CHANNEL_COUNT, 17'd1);
    program_register(CFG_PIXEL_COUNT, 17'd1);
    program_register(CFG_RECIPROCAL, 17'h1ffff);
    @(negedge clk_i);
    sample_backlog = '{16'sd30000, -16'sd30000, 16'sd1};
    settle_pipeline();

    // Zero reciprocal
    program_register(CFG_RECIPROCAL, 17'd0);
    @(negedge clk_i);
    sample_backlog.push_back(16'sd12345);
    settle_pipeline();

    // Rounding half up at exact halves, positive and negative
    program_register(CFG_RECIPROCAL, 17'd32768);
    @(negedge clk_i);
    sample_backlog = '{16'sd1, -16'sd1, -16'sd3};
    settle_pipeline();

    // Zero channel and pixel counts act as one
    program_register(CFG_CHANNEL_COUNT, 17'd0);
    program_register(CFG_PIXEL_COUNT, 17'd0);
    program_register(CFG_RECIPROCAL, 17'd65536);
    @(negedge clk_i);
    sample_backlog = '{16'sd7, -16'sd7};
    settle_pipeline();

    // Counts above the maximum saturate; then cut the image short mid-way
    program_register(CFG_CHANNEL_COUNT, 17'd2047);
    program_register(CFG_PIXEL_COUNT, 17'h1ffff);
    @(negedge clk_i);
    repeat (3) sample_backlog.push_back(random_sample());
    settle_pipeline();
    program_register(CFG_PIXEL_COUNT, 17'd1);
    @(negedge clk_i);
    sample_backlog.push_back(random_sample());
    settle_pipeline();
    program_register(CFG_CHANNEL_COUNT, 17'd1);
    @(negedge clk_i);
    sample_backlog.push_back(random_sample());
    settle_pipeline();

    // Random phases: mostly whole images, some cut short by the next change
    while (random_items < RANDOM_ITEMS || means_seen < RESULTS_WANT) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0: cand = $urandom_range(POOL_CHANNELS + 1, 2047);
          1: cand = 0;
          2: cand = POOL_CHANNELS;
          default: cand = $urandom_range(1, 12);
        endcase
        if (!channel_count_safe(eff_channels(CCOUNT_W'(cand)))) cand = 32'(ccount_reg);
        word = CFG_DATA_W'(cand);
        if ($urandom_range(0, 3) == 0)
          word[CFG_DATA_W-1:CCOUNT_W] = 6'($urandom);
        program_register(CFG_CHANNEL_COUNT, word);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0: word = 17'd0;
          1: word = 17'd65536;
          2: word = CFG_DATA_W'($urandom_range(65537, 131071));
          default: word = CFG_DATA_W'($urandom_range(1, 6));
        endcase
        program_register(CFG_PIXEL_COUNT, word);
      end
      if ($urandom_range(0, 2) != 0) begin
        npx = eff_pixels(pcount_reg);
        case ($urandom_range(0, 9))
          0: word = 17'd0;
          1: word = 17'd65536;
          2: word = 17'h1ffff;
          3, 4: word = CFG_DATA_W'($urandom_range(0, 131071));
          default: word = CFG_DATA_W'((65536 + npx / 2) / npx);
        endcase
        program_register(CFG_RECIPROCAL, word);
      end

      n_items = items_to_image_end() +
                $urandom_range(0, 3) * eff_channels(ccount_reg) * eff_pixels(pcount_reg);
      if ($urandom_range(0, 4) == 0 || n_items > 120) n_items = $urandom_range(1, 12);
      @(negedge clk_i);
      repeat (n_items) sample_backlog.push_back(random_sample());
      random_items += n_items;
      settle_pipeline();
    end

    if (mismatches == 0) begin
      $display("global_average_pool_channels_tb OK");
    end else begin
      $display("global_average_pool_channels_tb NOT OK");
    end
    $finish;
  end

endmodule
